[sv/frt_pkg.sv]
// shared types and constants for the frame receiver with timeout
// no dependencies; used by frt_front, frt_queue, frt_back and the top level
package frt_pkg;

  // framing characters
  localparam logic [7:0] ChEnq = 8'h05;
  localparam logic [7:0] ChQry = 8'h3F;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEtx = 8'h03;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChLf  = 8'h0A;

  // result event codes
  localparam logic [2:0] EvStored = 3'd0;
  localparam logic [2:0] EvLast   = 3'd1;
  localparam logic [2:0] EvAck    = 3'd2;
  localparam logic [2:0] EvEnq    = 3'd3;
  localparam logic [2:0] EvAbort  = 3'd4;

  localparam logic [31:0] TimeoutReset = 32'd1000;

  // class of a character as seen by an idle receiver
  typedef enum logic [2:0] {
    CLS_ENQ,
    CLS_QRY,
    CLS_STX_ETX,
    CLS_ACK_LF,
    CLS_OTHER
  } char_class_e;

  // classified input transaction handed from the front to the back
  typedef struct packed {
    logic        is_tick;
    logic        dropped;
    char_class_e cls;
    logic [7:0]  data;
  } item_t;

endpackage

[sv/frt_front.sv]
// front end: takes input transactions and classifies characters
// depends on frt_pkg; feeds frt_queue
module frt_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          kind_i,
  input  logic [7:0]    data_byte_i,
  input  logic [3:0]    error_flags_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output frt_pkg::item_t q_item_o
);

  frt_pkg::char_class_e cls;

  // idle-state character class
  always_comb begin
    unique case (data_byte_i)
      frt_pkg::ChEnq:                cls = frt_pkg::CLS_ENQ;
      frt_pkg::ChQry:                cls = frt_pkg::CLS_QRY;
      frt_pkg::ChStx, frt_pkg::ChEtx: cls = frt_pkg::CLS_STX_ETX;
      frt_pkg::ChAck, frt_pkg::ChLf:  cls = frt_pkg::CLS_ACK_LF;
      default:                       cls = frt_pkg::CLS_OTHER;
    endcase
  end

  // stall only while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  assign q_item_o.is_tick = kind_i;
  assign q_item_o.dropped = (error_flags_i != 4'd0);
  assign q_item_o.cls     = cls;
  assign q_item_o.data    = data_byte_i;

endmodule

[sv/frt_queue.sv]
// short queue of classified transactions between front and back
// depends on frt_pkg
module frt_queue #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  frt_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output frt_pkg::item_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  frt_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[sv/frt_back.sv]
// back end: frame state, timeout timer and the registered result stage
// depends on frt_pkg; drains frt_queue
module frt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           q_empty_i,
  input  frt_pkg::item_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     event_res_o,
  output logic [7:0]     out_byte_o,
  output logic [8:0]     position_o,
  output logic [8:0]     frame_length_o
);

  logic [31:0] timeout_q;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  rem_q, rem_d;
  logic [31:0] ticks_q, ticks_d;
  logic        run_q, run_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  ev_q, ev_d;
  logic [7:0]  byte_q, byte_d;
  logic [8:0]  opos_q, opos_d;
  logic [8:0]  len_q, len_d;
  logic        res_valid;
  logic        slot_free;
  logic        step;

  // the result register can take a new value when empty or being drained
  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign step      = slot_free & ~q_empty_i;
  assign q_pop_o   = step;

  // process one transaction from the queue head
  always_comb begin
    pos_d     = pos_q;
    rem_d     = rem_q;
    ticks_d   = ticks_q;
    run_d     = run_q;
    res_valid = 1'b0;
    ev_d      = frt_pkg::EvStored;
    byte_d    = 8'd0;
    opos_d    = 9'd0;
    len_d     = 9'd0;
    if (step) begin
      if (q_head_i.is_tick) begin
        // timer tick
        if (run_q) begin
          if (ticks_q > 32'd1) begin
            ticks_d = ticks_q - 32'd1;
          end else begin
            ticks_d = 32'd0;
            run_d   = 1'b0;
            rem_d   = 8'd0;
            if (pos_q != 9'd0) begin
              pos_d     = 9'd0;
              res_valid = 1'b1;
              ev_d      = frt_pkg::EvAbort;
            end
          end
        end
      end else begin
        // any character reloads the timer
        ticks_d = timeout_q;
        run_d   = 1'b1;
        if (!q_head_i.dropped) begin
          if (rem_q == 8'd0) begin
            if (pos_q == 9'd0) begin
              unique case (q_head_i.cls)
                frt_pkg::CLS_ENQ: begin
                  res_valid = 1'b1;
                  ev_d      = frt_pkg::EvEnq;
                end
                frt_pkg::CLS_QRY: begin
                  rem_d     = 8'd1;
                  pos_d     = 9'd1;
                  res_valid = 1'b1;
                  ev_d      = frt_pkg::EvStored;
                  byte_d    = q_head_i.data;
                end
                frt_pkg::CLS_STX_ETX: begin
                  pos_d     = 9'd1;
                  res_valid = 1'b1;
                  ev_d      = frt_pkg::EvStored;
                  byte_d    = q_head_i.data;
                end
                frt_pkg::CLS_ACK_LF: begin
                  res_valid = 1'b1;
                  ev_d      = frt_pkg::EvAck;
                  byte_d    = q_head_i.data;
                  len_d     = 9'd1;
                end
                default: begin
                  res_valid = 1'b0;
                end
              endcase
            end else if (pos_q == 9'd1) begin
              // length byte
              rem_d     = q_head_i.data + 8'd3;
              pos_d     = 9'd2;
              res_valid = 1'b1;
              ev_d      = frt_pkg::EvStored;
              byte_d    = q_head_i.data;
              opos_d    = 9'd1;
            end
          end else begin
            // frame body byte
            res_valid = 1'b1;
            byte_d    = q_head_i.data;
            opos_d    = pos_q;
            rem_d     = rem_q - 8'd1;
            if (rem_q == 8'd1) begin
              ev_d  = frt_pkg::EvLast;
              len_d = pos_q + 9'd1;
              pos_d = 9'd0;
            end else begin
              ev_d  = frt_pkg::EvStored;
              pos_d = pos_q + 9'd1;
            end
          end
        end
      end
    end
  end

  // result register handshake
  always_comb begin
    if (step) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= frt_pkg::TimeoutReset;
      pos_q       <= 9'd0;
      rem_q       <= 8'd0;
      ticks_q     <= 32'd0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      ticks_q     <= ticks_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only when a new transaction is processed
  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      ev_q   <= ev_d;
      byte_q <= byte_d;
      opos_q <= opos_d;
      len_q  <= len_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign out_byte_o     = byte_q;
  assign position_o     = opos_q;
  assign frame_length_o = len_q;

endmodule

[sv/frame_receiver_with_timeout.sv]
// Frame receiver with inter-character timeout for one serial port.
// Input channel (valid/stall): kind_i selects a received character (0) or a
// timer tick (1); data_byte_i and error_flags_i go with a character.
// Output channel (valid/stall): one result transaction per character that
// is stored, ends a frame, is a single ack byte or an enquiry, and per tick
// that aborts a partial frame; other transactions give no result.
// A result is registered: an accepted input transaction passes through
// the queue and then through the result register.
// Throughput: one input transaction per cycle while in_stall_o is low,
// set by the combinational frame update in the back end.
// A queue of FifoDepth entries sits between the classifying front end and
// the back end; in_stall_o rises only when that queue is full, which needs
// a result held by a stalled output.
// A stalled result holds; the queue behind it keeps FifoDepth more inputs.
// Reset clears the frame state, stops the timer, empties the queue and
// sets timeout_ticks to 1000. cfg_we_i writes timeout_ticks and should
// only be used while the block is idle.
// depends on frt_pkg, frt_front, frt_queue, frt_back
module frame_receiver_with_timeout #(
  parameter int FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [3:0]  error_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  out_byte_o,
  output logic [8:0]  position_o,
  output logic [8:0]  frame_length_o
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  frt_pkg::item_t push_item;
  frt_pkg::item_t head_item;

  // classify incoming transactions
  frt_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .error_flags_i (error_flags_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  // decoupling queue
  frt_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  // frame tracking, timer and result register
  frt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_empty_i      (q_empty),
    .q_head_i       (head_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .out_byte_o     (out_byte_o),
    .position_o     (position_o),
    .frame_length_o (frame_length_o)
  );

endmodule

[sim/tb_frame_receiver_with_timeout.sv]
// self-checking testbench for frame_receiver_with_timeout
// depends on frt_pkg and the frame_receiver_with_timeout rtl; reads no files
module tb_frame_receiver_with_timeout;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;

  // one input transaction and one result transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] err;
  } rx_item_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] data;
    logic [8:0] pos;
    logic [8:0] len;
  } rx_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic [3:0]  error_flags_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [7:0]  out_byte_o;
  logic [8:0]  position_o;
  logic [8:0]  frame_length_o;

  rx_item_t   char_queue[$];
  rx_result_t expected_results[$];
  rx_item_t   driven_item;
  int         chars_queued = 0;
  int         chars_accepted = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  logic       no_idle = 1'b0;

  // receiver state as the predictor sees it
  logic [8:0]  rx_pos = '0;
  logic [7:0]  rx_remaining = '0;
  logic [31:0] rx_ticks = '0;
  logic        rx_timer_on = 1'b0;
  logic [31:0] rx_timeout = frt_pkg::TimeoutReset;

  frame_receiver_with_timeout dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .error_flags_i  (error_flags_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .out_byte_o     (out_byte_o),
    .position_o     (position_o),
    .frame_length_o (frame_length_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // advance the receiver by one transaction and queue the result it causes
  function automatic void predict_receiver(rx_item_t it);
    rx_result_t res;
    logic       hit;
    logic [8:0] pos;
    res = '0;
    hit = 1'b0;
    if (it.kind) begin
      if (rx_timer_on) begin
        if (rx_ticks > 32'd1) begin
          rx_ticks = rx_ticks - 32'd1;
        end else begin
          rx_ticks = '0;
          rx_timer_on = 1'b0;
          if (rx_pos != '0) begin
            res = '{frt_pkg::EvAbort, 8'd0, 9'd0, 9'd0};
            hit = 1'b1;
          end
          rx_pos = '0;
          rx_remaining = '0;
        end
      end
    end else begin
      rx_ticks = rx_timeout;
      rx_timer_on = 1'b1;
      if (it.err == '0) begin
        if (rx_remaining == '0) begin
          if (rx_pos == '0) begin
            hit = 1'b1;
            if (it.data == frt_pkg::ChEnq) begin
              res = '{frt_pkg::EvEnq, 8'd0, 9'd0, 9'd0};
            end else if (it.data == frt_pkg::ChQry) begin
              rx_remaining = 8'd1;
              rx_pos = 9'd1;
              res = '{frt_pkg::EvStored, it.data, 9'd0, 9'd0};
            end else if (it.data == frt_pkg::ChStx || it.data == frt_pkg::ChEtx) begin
              rx_pos = 9'd1;
              res = '{frt_pkg::EvStored, it.data, 9'd0, 9'd0};
            end else if (it.data == frt_pkg::ChAck || it.data == frt_pkg::ChLf) begin
              res = '{frt_pkg::EvAck, it.data, 9'd0, 9'd1};
            end else begin
              hit = 1'b0;
            end
          end else if (rx_pos == 9'd1) begin
            // length byte; the count wraps at 8 bits
            rx_remaining = it.data + 8'd3;
            rx_pos = 9'd2;
            res = '{frt_pkg::EvStored, it.data, 9'd1, 9'd0};
            hit = 1'b1;
          end
        end else begin
          pos = rx_pos;
          rx_pos = rx_pos + 9'd1;
          rx_remaining = rx_remaining - 8'd1;
          hit = 1'b1;
          if (rx_remaining == '0) begin
            res = '{frt_pkg::EvLast, it.data, pos, rx_pos};
            rx_pos = '0;
          end else begin
            res = '{frt_pkg::EvStored, it.data, pos, 9'd0};
          end
        end
      end
    end
    if (hit) expected_results.push_back(res);
  endfunction

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // driver: offer the next queued transaction once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_receiver(driven_item);
        chars_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (char_queue.size() > 0) begin
          driven_item = char_queue.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= driven_item.kind;
          data_byte_i <= driven_item.data;
          error_flags_i <= driven_item.err;
          send_gap = idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    rx_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result expected none actual ev=%0d byte=%0d pos=%0d len=%0d",
                   $time, event_res_o, out_byte_o, position_o, frame_length_o);
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", want.ev, event_res_o);
          check_field("out_byte", want.data, out_byte_o);
          check_field("position", want.pos, position_o);
          check_field("frame_length", want.len, frame_length_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_len();
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb_frame_receiver_with_timeout: FAIL");
      $finish;
    end
  end

  function automatic void add_char(logic [7:0] d, logic [3:0] err);
    char_queue.push_back('{1'b0, d, err});
    chars_queued++;
  endfunction

  // data and flags of a tick are don't-care, so they are randomized
  function automatic void add_tick();
    char_queue.push_back('{1'b1, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))});
    chars_queued++;
  endfunction

  // enough ticks after the last character to expire the timer
  function automatic void add_expiry(logic [31:0] tmo);
    repeat ((tmo == '0) ? 1 : tmo) add_tick();
  endfunction

  // one frame byte, sometimes behind a dropped character or a harmless tick
  function automatic void add_payload(logic [31:0] tmo);
    if ($urandom_range(0, 99) < 8) add_char(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)));
    if (tmo > 32'd1 && $urandom_range(0, 99) < 5) add_tick();
    add_char(8'($urandom_range(0, 255)), 4'h0);
  endfunction

  // well-formed frame with random content, or one cut short and left to time out
  function automatic void add_frame(logic [31:0] tmo, logic cut_short);
    int sel;
    int r;
    int lval;
    int n_bytes;
    int keep;
    sel = $urandom_range(0, 9);
    if (!cut_short && sel < 3) begin
      add_char((sel == 0) ? frt_pkg::ChEnq : (sel == 1) ? frt_pkg::ChAck : frt_pkg::ChLf,
               4'h0);
      return;
    end
    if (!cut_short && sel < 5) begin
      add_char(frt_pkg::ChQry, 4'h0);
      add_payload(tmo);
      return;
    end
    r = $urandom_range(0, 9);
    lval = (r < 4) ? $urandom_range(253, 255) : (r < 8) ? $urandom_range(0, 12)
                   : $urandom_range(13, 40);
    // a zero-length frame only clears by timeout
    if (lval == 253 && tmo > 32'd40) lval = 254;
    n_bytes = (lval + 3) % 256;
    keep = (n_bytes == 0) ? 0 : $urandom_range(0, n_bytes - 1);
    add_char($urandom_range(0, 1) ? frt_pkg::ChStx : frt_pkg::ChEtx, 4'h0);
    if (cut_short && $urandom_range(0, 3) == 0) begin
      add_expiry(tmo);
      return;
    end
    add_char(8'(lval), 4'h0);
    repeat (cut_short ? keep : n_bytes) add_payload(tmo);
    if (cut_short || n_bytes == 0) add_expiry(tmo);
  endfunction

  task automatic write_timeout(logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    rx_timeout = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (chars_accepted != chars_queued || expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly frames; noise, broken frames and timer expiry in between
  task automatic random_phase(logic [31:0] tmo, int n, logic quiet);
    int first;
    int r;
    logic [7:0] d;
    write_timeout(tmo);
    no_idle = quiet;
    first = chars_queued;
    if (tmo == '1) begin
      // longest frame: positions up to 256, length 257
      add_char(frt_pkg::ChStx, 4'h0);
      add_char(8'd252, 4'h0);
      repeat (255) add_char(8'($urandom_range(0, 255)), 4'h0);
    end
    while (chars_queued - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        add_frame(tmo, 1'b0);
      end else if (r < 78 && tmo <= 32'd40) begin
        add_frame(tmo, 1'b1);
      end else if (r < 84) begin
        add_tick();
      end else if (r < 90) begin
        add_char(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)));
      end else if (r < 95) begin
        // idle character that starts nothing
        do d = 8'($urandom_range(0, 255));
        while (d == frt_pkg::ChEnq || d == frt_pkg::ChQry || d == frt_pkg::ChStx ||
               d == frt_pkg::ChEtx || d == frt_pkg::ChAck || d == frt_pkg::ChLf);
        add_char(d, 4'h0);
      end else if (tmo <= 32'd40) begin
        add_expiry(tmo);
      end else begin
        add_tick();
      end
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    // directed: every frame start, field extremes and dropped characters
    add_tick();
    add_char(frt_pkg::ChEnq, 4'h0);
    add_char(frt_pkg::ChAck, 4'h0);
    add_char(frt_pkg::ChLf, 4'h0);
    add_char(frt_pkg::ChQry, 4'h0);
    add_char(8'hFF, 4'h0);
    add_char(frt_pkg::ChStx, 4'h0);
    add_char(8'hFF, 4'h0);
    add_char(8'h00, 4'h0);
    add_char(8'hFF, 4'h0);
    add_char(frt_pkg::ChEtx, 4'h0);
    add_char(8'h00, 4'h0);
    add_char(8'hA5, 4'h0);
    add_char(8'h5A, 4'h0);
    add_char(8'h3C, 4'h0);
    add_char(8'hFF, 4'h0);
    add_char(frt_pkg::ChEnq, 4'hF);
    add_char(frt_pkg::ChAck, 4'h1);
    add_char(8'h00, 4'h2);
    add_char(frt_pkg::ChQry, 4'h4);
    add_char(frt_pkg::ChStx, 4'h8);
    // a few ticks inside a frame stay below the reset timeout
    add_char(frt_pkg::ChStx, 4'h0);
    add_char(8'h00, 4'h0);
    repeat (4) add_tick();
    repeat (3) add_char(8'($urandom_range(0, 255)), 4'h0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // zero-length frame stalls until aborted; timeout with nothing pending
    write_timeout(32'd3);
    add_char(frt_pkg::ChEtx, 4'h0);
    add_char(8'hFD, 4'h0);
    add_char(8'h41, 4'h0);
    add_char(frt_pkg::ChEnq, 4'h0);
    add_expiry(32'd3);
    add_char(frt_pkg::ChAck, 4'h0);
    add_expiry(32'd3);
    add_tick();
    wait_drained();

    // zero register expires on the first tick
    write_timeout(32'd0);
    add_char(frt_pkg::ChStx, 4'h0);
    add_tick();
    add_char(frt_pkg::ChQry, 4'h0);
    add_char(8'h00, 4'h3);
    add_tick();
    add_tick();
    wait_drained();

    random_phase(32'd1, 20, 1'b0);
    random_phase(32'd2, 15, 1'b1);
    random_phase(32'd5, 20, 1'b0);
    random_phase(32'd12, 20, 1'b0);
    random_phase(32'($urandom_range(1, 8)), 15, 1'b0);
    random_phase(32'hFFFF_FFFF, 15, 1'b0);
    random_phase(frt_pkg::TimeoutReset, 15, 1'b0);

    if (error_count == 0) begin
      $display("tb_frame_receiver_with_timeout: PASS");
    end else begin
      $display("tb_frame_receiver_with_timeout: FAIL");
    end
    $finish;
  end

endmodule
